// ===== design/esc_pkg.sv =====
// esc_pkg: shared types, constants and arithmetic helpers for the
// environmental sensor compensation pipeline; no dependencies
package esc_pkg;

  typedef enum logic [2:0] {
    CFG_CAL_TEMP      = 3'd0,
    CFG_CAL_PRESS_A   = 3'd1,
    CFG_CAL_PRESS_B   = 3'd2,
    CFG_CAL_PRESS_HUM = 3'd3,
    CFG_CAL_HUM_B     = 3'd4
  } cfg_idx_t;

  localparam int unsigned DIV_STEPS = 64;

  localparam logic [63:0] P_OFFSET    = 64'd128000;
  localparam logic [63:0] PN_BASE     = 64'd1048576;
  localparam logic [63:0] P_NUM_SCALE = 64'd3125;
  localparam logic [63:0] E_BIAS      = 64'h0000_8000_0000_0000;
  localparam logic [31:0] T_ROUND     = 32'd128;
  localparam logic [31:0] H_OFFSET    = 32'd76800;
  localparam logic [31:0] H_U_ROUND   = 32'd16384;
  localparam logic [31:0] H_W_BIAS    = 32'd32768;
  localparam logic [31:0] H_W_OFFSET  = 32'd2097152;
  localparam logic [31:0] H_W_ROUND   = 32'd8192;
  localparam logic [31:0] H_MAX       = 32'd419430400;

  // coefficients, sign or zero extended to the working width
  typedef struct packed {
    logic [31:0] t1;
    logic [31:0] t2;
    logic [31:0] t3;
    logic [63:0] p1;
    logic [63:0] p2;
    logic [63:0] p3;
    logic [63:0] p4;
    logic [63:0] p5;
    logic [63:0] p6;
    logic [63:0] p7;
    logic [63:0] p8;
    logic [63:0] p9;
    logic [31:0] h1;
    logic [31:0] h2;
    logic [31:0] h3;
    logic [31:0] h4;
    logic [31:0] h5;
    logic [31:0] h6;
  } cal_t;

  typedef struct packed {
    logic [19:0] raw_temp;
    logic [19:0] raw_press;
    logic [15:0] raw_hum;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] temp_centideg;
    logic [31:0]        press_q24_8;
    logic [16:0]        hum_q22_10;
  } out_word_t;

  typedef struct packed {
    logic [31:0] temp;
    logic [16:0] hum;
  } side_t;

  // partial products of a product modulo 2^64
  typedef struct packed {
    logic [63:0] ll;
    logic [31:0] c0;
    logic [31:0] c1;
  } mul_part_t;

  function automatic mul_part_t mul_part(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] p0;
    logic [63:0] p1;
    logic [63:0] p2;
    mul_part_t   r;
    p0 = a[31:0] * b[31:0];
    p1 = a[31:0] * b[63:32];
    p2 = a[63:32] * b[31:0];
    r.ll = p0;
    r.c0 = p1[31:0];
    r.c1 = p2[31:0];
    return r;
  endfunction

  function automatic logic [63:0] mul_join(input mul_part_t m);
    logic [31:0] c;
    c = m.c0 + m.c1;
    return m.ll + {c, 32'd0};
  endfunction

  function automatic logic [31:0] asr32(input logic [31:0] v, input logic [4:0] sh);
    logic signed [31:0] t;
    t = v;
    return t >>> sh;
  endfunction

  function automatic logic [63:0] asr64(input logic [63:0] v, input logic [5:0] sh);
    logic signed [63:0] t;
    t = v;
    return t >>> sh;
  endfunction

endpackage

// ===== design/esc_stream_if.sv =====
// esc_stream_if: valid/ready channel carrying one word of type word_t
// used by the top level for its input and result channels
interface esc_stream_if #(parameter type word_t = logic);
  logic  valid;
  logic  ready;
  word_t word;

  modport source (output valid, output word, input ready);
  modport sink   (input valid, input word, output ready);
endinterface

// ===== design/env_sensor_compensation.sv =====
// env_sensor_compensation: top level, calibration registers, stall control
// and output register; depends on esc_pkg, esc_stream_if, esc_front,
// esc_div and esc_post
//
// Input channel in_if carries one raw measurement word (raw_temp,
// raw_press, raw_hum); result channel out_if carries one word
// (temp_centideg, press_q24_8, hum_q22_10) for each input word, in order.
// Calibration is written through cfg_we / cfg_index / cfg_wdata; the user
// must write it only while no word is in flight, as the block itself does
// not enforce this. Unknown indexes are ignored. Throughput: one word per
// cycle while in_if.ready is high. From acceptance to out_if.valid a word
// passes the 13 front stages, the divider (sign stage, one stage per
// quotient bit, sign fix), the 6 post stages and the output register.
// Reset (rst_n low, synchronous) clears all calibration registers to zero
// and empties the pipeline.
// When the receiver stalls, the result waits in the output register and
// words keep entering until a valid word reaches the last stage; only then
// does in_if.ready drop, and the whole pipeline holds.
module env_sensor_compensation import esc_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  esc_stream_if.sink          in_if,
  esc_stream_if.source        out_if,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_index,
  input  logic [63:0]         cfg_wdata
);

  logic [47:0] cal_temp_r;
  logic [63:0] cal_press_a_r;
  logic [63:0] cal_press_b_r;
  logic [47:0] cal_press_hum_r;
  logic [31:0] cal_hum_b_r;
  cal_t        cal;

  logic        en;
  logic        front_vld, div_vld, post_vld;
  logic [63:0] num, den, quot;
  logic        dz;
  side_t       front_side, div_side;
  out_word_t   post_word;
  logic        out_valid_r;
  out_word_t   out_word_r;
  in_word_t    in_word;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cal_temp_r      <= '0;
      cal_press_a_r   <= '0;
      cal_press_b_r   <= '0;
      cal_press_hum_r <= '0;
      cal_hum_b_r     <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_CAL_TEMP:      cal_temp_r      <= cfg_wdata[47:0];
        CFG_CAL_PRESS_A:   cal_press_a_r   <= cfg_wdata;
        CFG_CAL_PRESS_B:   cal_press_b_r   <= cfg_wdata;
        CFG_CAL_PRESS_HUM: cal_press_hum_r <= cfg_wdata[47:0];
        CFG_CAL_HUM_B:     cal_hum_b_r     <= cfg_wdata[31:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    cal.t1 = {16'd0, cal_temp_r[15:0]};
    cal.t2 = {{16{cal_temp_r[31]}}, cal_temp_r[31:16]};
    cal.t3 = {{16{cal_temp_r[47]}}, cal_temp_r[47:32]};
    cal.p1 = {48'd0, cal_press_a_r[15:0]};
    cal.p2 = {{48{cal_press_a_r[31]}}, cal_press_a_r[31:16]};
    cal.p3 = {{48{cal_press_a_r[47]}}, cal_press_a_r[47:32]};
    cal.p4 = {{48{cal_press_a_r[63]}}, cal_press_a_r[63:48]};
    cal.p5 = {{48{cal_press_b_r[15]}}, cal_press_b_r[15:0]};
    cal.p6 = {{48{cal_press_b_r[31]}}, cal_press_b_r[31:16]};
    cal.p7 = {{48{cal_press_b_r[47]}}, cal_press_b_r[47:32]};
    cal.p8 = {{48{cal_press_b_r[63]}}, cal_press_b_r[63:48]};
    cal.p9 = {{48{cal_press_hum_r[15]}}, cal_press_hum_r[15:0]};
    cal.h1 = {24'd0, cal_press_hum_r[23:16]};
    cal.h2 = {{16{cal_press_hum_r[39]}}, cal_press_hum_r[39:24]};
    cal.h3 = {24'd0, cal_press_hum_r[47:40]};
    cal.h4 = {{20{cal_hum_b_r[11]}}, cal_hum_b_r[11:0]};
    cal.h5 = {{20{cal_hum_b_r[23]}}, cal_hum_b_r[23:12]};
    cal.h6 = {{24{cal_hum_b_r[31]}}, cal_hum_b_r[31:24]};
  end

  // pipeline holds only when a finished word cannot move on
  assign en          = !post_vld || !out_valid_r || out_if.ready;
  assign in_if.ready = en;
  assign in_word     = in_if.word;

  esc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (in_if.valid),
    .in_word   (in_word),
    .cal       (cal),
    .out_valid (front_vld),
    .num       (num),
    .den       (den),
    .side      (front_side)
  );

  esc_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (front_vld),
    .num       (num),
    .den       (den),
    .side_in   (front_side),
    .out_valid (div_vld),
    .quot      (quot),
    .dz        (dz),
    .side_out  (div_side)
  );

  esc_post u_post (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (div_vld),
    .quot      (quot),
    .dz        (dz),
    .side      (div_side),
    .cal       (cal),
    .out_valid (post_vld),
    .word      (post_word)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (post_vld && en) begin
      out_valid_r <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (post_vld && en) begin
      out_word_r <= post_word;
    end
  end

  assign out_if.valid = out_valid_r;
  assign out_if.word  = out_word_r;

  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_if.valid |-> in_if.ready)
    else $error("input stalled with empty output register");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_if.ready |-> (out_if.valid && !out_if.ready))
    else $error("input stalled without a blocked output word");

  a_hum_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_if.valid |-> (out_if.word.hum_q22_10 <= 17'd102400))
    else $error("humidity out of range");

endmodule

// ===== design/esc_front.sv =====
// esc_front: temperature, humidity and the pressure dividend and divisor
// thirteen register stages; depends on esc_pkg
module esc_front import esc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        en,
  input  logic        in_valid,
  input  in_word_t    in_word,
  input  cal_t        cal,
  output logic        out_valid,
  output logic [63:0] num,
  output logic [63:0] den,
  output side_t       side
);

  logic [13:1] vld_r;

  logic [31:0] a_t2_r, bb_r, va_r, bbt3_r, tfine_r;
  logic [63:0] v1_r;
  logic [31:0] hx_r, h5x_r, xh6_r, xh3_r, u6_r, u7_r, u8_r, u9_r;
  logic [31:0] wa_r, wb_r, w0_r, wh2_r, w9_r, x2_r, x2_11_r, x2_12_r, ss_r, sh1_r;
  logic [19:0] adcp1_r, adcp2_r, adcp3_r, adcp4_r, adcp5_r, adcp6_r, adcp7_r;
  logic [19:0] adcp8_r, adcp9_r;
  logic [15:0] adch1_r, adch2_r, adch3_r, adch4_r, adch5_r;
  logic [31:0] temp4_r, temp5_r, temp6_r, temp7_r, temp8_r, temp9_r, temp10_r;
  logic [31:0] temp11_r, temp12_r;
  mul_part_t   mv1sq_r, mv1p5_r, mv1p2_r, mv2a_r, mv1c_r, mprod_r, mnum_r;
  logic [63:0] v1sq_r, v1p5_r, v1p2_r, v1p5_7_r, v1p2_7_r, v1p5_8_r, v1p2_8_r;
  logic [63:0] v2a_r, v1c_r, v2_r, v1m_r, e_r, n0_r, prod_r, num12_r;
  logic [63:0] num_r, den_r;
  side_t       side_r;

  logic [31:0] a_s, b_s, t5, x3, hc;

  always_comb begin
    a_s = 32'(in_word.raw_temp[19:3]) - (cal.t1 << 1);
    b_s = 32'(in_word.raw_temp[19:4]) - cal.t1;
    t5  = (tfine_r << 2) + tfine_r + T_ROUND;
    x3  = x2_12_r - asr32(sh1_r, 5'd4);
    if (x3[31]) begin
      hc = 32'd0;
    end else if (x3 > H_MAX) begin
      hc = H_MAX;
    end else begin
      hc = x3;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[12:1], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // temperature
      a_t2_r  <= a_s * cal.t2;
      bb_r    <= b_s * b_s;
      adcp1_r <= in_word.raw_press;
      adch1_r <= in_word.raw_hum;

      va_r    <= asr32(a_t2_r, 5'd11);
      bbt3_r  <= asr32(bb_r, 5'd12) * cal.t3;
      adcp2_r <= adcp1_r;
      adch2_r <= adch1_r;

      tfine_r <= va_r + asr32(bbt3_r, 5'd14);
      adcp3_r <= adcp2_r;
      adch3_r <= adch2_r;

      temp4_r <= asr32(t5, 5'd8);
      v1_r    <= {{32{tfine_r[31]}}, tfine_r} - P_OFFSET;
      hx_r    <= tfine_r - H_OFFSET;
      adcp4_r <= adcp3_r;
      adch4_r <= adch3_r;

      // first products
      mv1sq_r <= mul_part(v1_r, v1_r);
      mv1p5_r <= mul_part(v1_r, cal.p5);
      mv1p2_r <= mul_part(v1_r, cal.p2);
      h5x_r   <= hx_r * cal.h5;
      xh6_r   <= hx_r * cal.h6;
      xh3_r   <= hx_r * cal.h3;
      temp5_r <= temp4_r;
      adcp5_r <= adcp4_r;
      adch5_r <= adch4_r;

      v1sq_r  <= mul_join(mv1sq_r);
      v1p5_r  <= mul_join(mv1p5_r);
      v1p2_r  <= mul_join(mv1p2_r);
      u6_r    <= asr32((32'(adch5_r) << 14) - (cal.h4 << 20) - h5x_r + H_U_ROUND, 5'd15);
      wa_r    <= asr32(xh6_r, 5'd10);
      wb_r    <= asr32(xh3_r, 5'd11) + H_W_BIAS;
      temp6_r <= temp5_r;
      adcp6_r <= adcp5_r;

      mv2a_r   <= mul_part(v1sq_r, cal.p6);
      mv1c_r   <= mul_part(v1sq_r, cal.p3);
      v1p5_7_r <= v1p5_r;
      v1p2_7_r <= v1p2_r;
      w0_r     <= wa_r * wb_r;
      u7_r     <= u6_r;
      temp7_r  <= temp6_r;
      adcp7_r  <= adcp6_r;

      v2a_r    <= mul_join(mv2a_r);
      v1c_r    <= mul_join(mv1c_r);
      v1p5_8_r <= v1p5_7_r;
      v1p2_8_r <= v1p2_7_r;
      wh2_r    <= (asr32(w0_r, 5'd10) + H_W_OFFSET) * cal.h2;
      u8_r     <= u7_r;
      temp8_r  <= temp7_r;
      adcp8_r  <= adcp7_r;

      v2_r    <= v2a_r + (v1p5_8_r << 17) + (cal.p4 << 35);
      v1m_r   <= asr64(v1c_r, 6'd8) + (v1p2_8_r << 12);
      w9_r    <= asr32(wh2_r + H_W_ROUND, 5'd14);
      u9_r    <= u8_r;
      temp9_r <= temp8_r;
      adcp9_r <= adcp8_r;

      e_r      <= E_BIAS + v1m_r;
      n0_r     <= ((PN_BASE - 64'(adcp9_r)) << 31) - v2_r;
      x2_r     <= u9_r * w9_r;
      temp10_r <= temp9_r;

      mprod_r  <= mul_part(e_r, cal.p1);
      mnum_r   <= mul_part(n0_r, P_NUM_SCALE);
      ss_r     <= asr32(x2_r, 5'd15) * asr32(x2_r, 5'd15);
      x2_11_r  <= x2_r;
      temp11_r <= temp10_r;

      prod_r   <= mul_join(mprod_r);
      num12_r  <= mul_join(mnum_r);
      sh1_r    <= asr32(ss_r, 5'd7) * cal.h1;
      x2_12_r  <= x2_11_r;
      temp12_r <= temp11_r;

      den_r       <= asr64(prod_r, 6'd33);
      num_r       <= num12_r;
      side_r.temp <= temp12_r;
      side_r.hum  <= hc[28:12];
    end
  end

  assign out_valid = vld_r[13];
  assign num       = num_r;
  assign den       = den_r;
  assign side      = side_r;

endmodule

// ===== design/esc_div.sv =====
// esc_div: pipelined signed 64-bit divider, one quotient bit per stage
// sign stage, 64 restoring steps, sign fix stage; depends on esc_pkg
module esc_div import esc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        en,
  input  logic        in_valid,
  input  logic [63:0] num,
  input  logic [63:0] den,
  input  side_t       side_in,
  output logic        out_valid,
  output logic [63:0] quot,
  output logic        dz,
  output side_t       side_out
);

  typedef struct packed {
    logic [63:0] rem;
    logic [63:0] nq;
    logic [63:0] dv;
    logic        neg;
    logic        dz;
    side_t       side;
  } div_st_t;

  div_st_t           st_r [DIV_STEPS+1];
  logic [DIV_STEPS+1:0] vld_r;
  logic [63:0]       q_r;
  logic              dz_r;
  side_t             side_r;

  function automatic div_st_t div_step(input div_st_t s);
    logic [64:0] sh;
    logic [64:0] df;
    div_st_t     r;
    sh = {s.rem, s.nq[63]};
    df = sh - {1'b0, s.dv};
    r  = s;
    if (!df[64]) begin
      r.rem = df[63:0];
      r.nq  = {s.nq[62:0], 1'b1};
    end else begin
      r.rem = sh[63:0];
      r.nq  = {s.nq[62:0], 1'b0};
    end
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[DIV_STEPS:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st_r[0].rem  <= 64'd0;
      st_r[0].nq   <= num[63] ? 64'd0 - num : num;
      st_r[0].dv   <= den[63] ? 64'd0 - den : den;
      st_r[0].neg  <= num[63] ^ den[63];
      st_r[0].dz   <= (den == 64'd0);
      st_r[0].side <= side_in;
      for (int k = 1; k <= DIV_STEPS; k++) begin
        st_r[k] <= div_step(st_r[k-1]);
      end
      q_r    <= st_r[DIV_STEPS].neg ? 64'd0 - st_r[DIV_STEPS].nq : st_r[DIV_STEPS].nq;
      dz_r   <= st_r[DIV_STEPS].dz;
      side_r <= st_r[DIV_STEPS].side;
    end
  end

  assign out_valid = vld_r[DIV_STEPS+1];
  assign quot      = q_r;
  assign dz        = dz_r;
  assign side_out  = side_r;

endmodule

// ===== design/esc_post.sv =====
// esc_post: pressure correction after the division and result assembly
// six register stages; depends on esc_pkg
module esc_post import esc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        en,
  input  logic        in_valid,
  input  logic [63:0] quot,
  input  logic        dz,
  input  side_t       side,
  input  cal_t        cal,
  output logic        out_valid,
  output out_word_t   word
);

  logic [6:1]  vld_r;
  mul_part_t   mq9_r, mq8_r, mw1_r;
  logic [63:0] q1_r, q2_r, q3_r, q4_r, qq1_r, qq2_r;
  logic [63:0] p9q_r, p8p_r, p8p3_r, p8p4_r, w1raw_r, sum_r;
  logic        dz1_r, dz2_r, dz3_r, dz4_r, dz5_r;
  side_t       side1_r, side2_r, side3_r, side4_r, side5_r;
  out_word_t   word_r;
  logic [63:0] qq, pr;

  always_comb begin
    qq = asr64(quot, 6'd13);
    pr = asr64(sum_r, 6'd8) + (cal.p7 << 4);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[5:1], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mq9_r   <= mul_part(cal.p9, qq);
      mq8_r   <= mul_part(cal.p8, quot);
      q1_r    <= quot;
      qq1_r   <= qq;
      dz1_r   <= dz;
      side1_r <= side;

      p9q_r   <= mul_join(mq9_r);
      p8p_r   <= mul_join(mq8_r);
      q2_r    <= q1_r;
      qq2_r   <= qq1_r;
      dz2_r   <= dz1_r;
      side2_r <= side1_r;

      mw1_r   <= mul_part(p9q_r, qq2_r);
      p8p3_r  <= p8p_r;
      q3_r    <= q2_r;
      dz3_r   <= dz2_r;
      side3_r <= side2_r;

      w1raw_r <= mul_join(mw1_r);
      p8p4_r  <= p8p3_r;
      q4_r    <= q3_r;
      dz4_r   <= dz3_r;
      side4_r <= side3_r;

      sum_r   <= q4_r + asr64(w1raw_r, 6'd25) + asr64(p8p4_r, 6'd19);
      dz5_r   <= dz4_r;
      side5_r <= side4_r;

      word_r.temp_centideg <= side5_r.temp;
      word_r.press_q24_8   <= dz5_r ? 32'd0 : pr[31:0];
      word_r.hum_q22_10    <= side5_r.hum;
    end
  end

  assign out_valid = vld_r[6];
  assign word      = word_r;

endmodule

// ===== dv/tb_env_sensor_compensation.sv =====
// tb_env_sensor_compensation: self-checking bench for the sensor compensation
// pipeline; directed table then random words checked against a local predictor
// depends on esc_pkg, esc_stream_if and env_sensor_compensation
`timescale 1ns / 100ps

module tb_env_sensor_compensation;
  import esc_pkg::*;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [63:0] cfg_wdata;

  esc_stream_if #(.word_t(in_word_t))  in_ch ();
  esc_stream_if #(.word_t(out_word_t)) out_ch ();

  env_sensor_compensation DUT (
    .clk(clk), .rst_n(rst_n), .in_if(in_ch.sink), .out_if(out_ch.source),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  typedef struct {
    in_word_t raw;
    logic     has_exp;
    out_word_t exp;
  } vec_t;

  logic [47:0] cal_temp_q;
  logic [63:0] cal_pa_q, cal_pb_q;
  logic [47:0] cal_ph_q;
  logic [31:0] cal_hb_q;
  out_word_t   exp_q[$];
  int          n_err;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #200ms;
    $display("Mismatches found");
    $finish;
  end

  function automatic logic signed [31:0] sx32(input logic [31:0] v, input int w);
    logic signed [31:0] t;
    t = v <<< (32 - w);
    return t >>> (32 - w);
  endfunction

  function automatic logic signed [63:0] sx64(input logic [63:0] v, input int w);
    logic signed [63:0] t;
    t = v <<< (64 - w);
    return t >>> (64 - w);
  endfunction

  function automatic out_word_t compensate(input in_word_t r);
    logic signed [31:0] t1, t2, t3, h1, h2, h3, h4, h5, h6;
    logic signed [31:0] a, va, b, vb, tfine, x, u, w, s;
    logic signed [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
    logic signed [63:0] v1, v2, p, q, w1, w2, n;
    logic [63:0] mn, md, uq;
    out_word_t o;
    t1 = {16'd0, cal_temp_q[15:0]};
    t2 = sx32(cal_temp_q[31:16], 16);
    t3 = sx32(cal_temp_q[47:32], 16);
    p1 = {48'd0, cal_pa_q[15:0]};
    p2 = sx64(cal_pa_q[31:16], 16);
    p3 = sx64(cal_pa_q[47:32], 16);
    p4 = sx64(cal_pa_q[63:48], 16);
    p5 = sx64(cal_pb_q[15:0], 16);
    p6 = sx64(cal_pb_q[31:16], 16);
    p7 = sx64(cal_pb_q[47:32], 16);
    p8 = sx64(cal_pb_q[63:48], 16);
    p9 = sx64(cal_ph_q[15:0], 16);
    h1 = {24'd0, cal_ph_q[23:16]};
    h2 = sx32(cal_ph_q[39:24], 16);
    h3 = {24'd0, cal_ph_q[47:40]};
    h4 = sx32(cal_hb_q[11:0], 12);
    h5 = sx32(cal_hb_q[23:12], 12);
    h6 = sx32(cal_hb_q[31:24], 8);
    a = $signed({15'd0, r.raw_temp[19:3]}) - (t1 <<< 1);
    va = (a * t2) >>> 11;
    b = $signed({16'd0, r.raw_temp[19:4]}) - t1;
    vb = (((b * b) >>> 12) * t3) >>> 14;
    tfine = va + vb;
    o.temp_centideg = (tfine * 5 + 128) >>> 8;

    o.press_q24_8 = '0;
    v1 = 64'(tfine) - 64'sd128000;
    v2 = v1 * v1 * p6;
    v2 = v2 + ((v1 * p5) <<< 17);
    v2 = v2 + (p4 <<< 35);
    v1 = ((v1 * v1 * p3) >>> 8) + ((v1 * p2) <<< 12);
    v1 = (((64'sd1 <<< 47) + v1) * p1) >>> 33;
    if (v1 != 0) begin
      p = 64'sd1048576 - $signed({44'd0, r.raw_press});
      n = ((p <<< 31) - v2) * 64'sd3125;
      mn = n[63] ? -n : n;
      md = v1[63] ? -v1 : v1;
      uq = mn / md;
      p = (n[63] != v1[63]) ? -uq : uq;
      q = p >>> 13;
      w1 = (p9 * q * q) >>> 25;
      w2 = (p8 * p) >>> 19;
      p = ((p + w1 + w2) >>> 8) + (p7 <<< 4);
      o.press_q24_8 = p[31:0];
    end

    x = tfine - 32'sd76800;
    u = (($signed({16'd0, r.raw_hum}) <<< 14) - (h4 <<< 20) - (h5 * x) + 16384) >>> 15;
    w = ((x * h6) >>> 10) * (((x * h3) >>> 11) + 32768);
    w = (w >>> 10) + 32'sd2097152;
    w = (w * h2 + 8192) >>> 14;
    x = u * w;
    s = x >>> 15;
    x = x - ((((s * s) >>> 7) * h1) >>> 4);
    if (x < 0) x = 0;
    else if (x > 32'sd419430400) x = 32'sd419430400;
    o.hum_q22_10 = x[28:12];
    return o;
  endfunction

  task automatic write_cal(input cfg_idx_t idx, input logic [63:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    case (idx)
      CFG_CAL_TEMP:      cal_temp_q = val[47:0];
      CFG_CAL_PRESS_A:   cal_pa_q   = val;
      CFG_CAL_PRESS_B:   cal_pb_q   = val;
      CFG_CAL_PRESS_HUM: cal_ph_q   = val[47:0];
      CFG_CAL_HUM_B:     cal_hb_q   = val[31:0];
      default: ;
    endcase
  endtask

  task automatic load_cal(input logic [47:0] ct, input logic [63:0] pa, input logic [63:0] pb,
                          input logic [47:0] ph, input logic [31:0] hb);
    write_cal(CFG_CAL_TEMP, {16'hFFFF, ct});
    write_cal(CFG_CAL_PRESS_A, pa);
    write_cal(CFG_CAL_PRESS_B, pb);
    write_cal(CFG_CAL_PRESS_HUM, {16'hFFFF, ph});
    write_cal(CFG_CAL_HUM_B, {32'hFFFF_FFFF, hb});
    cfg_we <= 1'b0;
  endtask

  task automatic send_word(input in_word_t r, input logic has_exp, input out_word_t e);
    out_word_t p;
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? (($urandom_range(0, 9) == 0) ?
          $urandom_range(10, 40) : $urandom_range(1, 3)) : 0;
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.word  <= r;
    do @(posedge clk); while (!in_ch.ready);
    p = compensate(r);
    if (has_exp && p != e) begin
      $error("table row disagrees with predictor: %h vs %h", e, p);
      n_err++;
    end
    exp_q.push_back(has_exp ? e : p);
  endtask

  task automatic drain;
    int guard;
    guard = 0;
    in_ch.valid <= 1'b0;
    while (exp_q.size() != 0 && guard < 100000) begin
      @(posedge clk);
      guard++;
    end
    repeat (100) @(posedge clk);
  endtask

  function automatic in_word_t rand_raw();
    in_word_t r;
    r.raw_temp  = $urandom_range(0, 3) == 0 ? 20'($urandom) : 20'($urandom_range(300000, 700000));
    r.raw_press = $urandom_range(0, 3) == 0 ? 20'($urandom) : 20'($urandom_range(250000, 550000));
    r.raw_hum   = 16'($urandom);
    return r;
  endfunction

  // result side: random stall and checks
  always @(posedge clk) begin
    out_word_t e;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (exp_q.size() == 0) begin
          $error("unexpected word %h", out_ch.word);
          n_err++;
        end else begin
          e = exp_q.pop_front();
          if (out_ch.word.temp_centideg !== e.temp_centideg) begin
            $error("temp_centideg exp %0d got %0d", e.temp_centideg, out_ch.word.temp_centideg);
            n_err++;
          end
          if (out_ch.word.press_q24_8 !== e.press_q24_8) begin
            $error("press_q24_8 exp %0d got %0d", e.press_q24_8, out_ch.word.press_q24_8);
            n_err++;
          end
          if (out_ch.word.hum_q22_10 !== e.hum_q22_10) begin
            $error("hum_q22_10 exp %0d got %0d", e.hum_q22_10, out_ch.word.hum_q22_10);
            n_err++;
          end
        end
      end
      if ($urandom_range(0, 99) < 3) out_ch.ready <= 1'b0;
      else if ($urandom_range(0, 99) < 40) out_ch.ready <= 1'b1;
    end
  end

  initial begin
    vec_t tbl[$];
    vec_t v;
    out_word_t z;
    in_word_t r;
    int ph;
    n_err = 0;
    cal_temp_q = '0; cal_pa_q = '0; cal_pb_q = '0; cal_ph_q = '0; cal_hb_q = '0;
    rst_n = 1'b0;
    cfg_we = 1'b0; cfg_index = '0; cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.word = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // all-zero calibration: zero divisor, every result field zero
    z = '0;
    v.has_exp = 1; v.exp = z;
    v.raw = '0;                                   tbl.push_back(v);
    v.raw = {20'hFFFFF, 20'hFFFFF, 16'hFFFF};     tbl.push_back(v);
    v.raw = {20'h80000, 20'h00001, 16'h8000};     tbl.push_back(v);
    foreach (tbl[i]) send_word(tbl[i].raw, tbl[i].has_exp, tbl[i].exp);
    drain();

    // write to an unused index, which the design ignores
    cfg_we <= 1'b1; cfg_index <= 3'd7; cfg_wdata <= '1;
    @(posedge clk);
    // typical datasheet calibration
    load_cal({16'hFC18, 16'd26435, 16'd27504},
             {16'd2855, 16'hFF4B, 16'hD0D0, 16'd36477},
             {16'hFFF9, 16'd15500, 16'hDB6F, 16'd140},
             {8'd0, 16'd362, 8'd75, 16'd6000},
             {8'd30, 12'd50, 12'd312});
    tbl.delete();
    v.has_exp = 0;
    v.raw = {20'd519888, 20'd415148, 16'd30000};  tbl.push_back(v);
    v.raw = '0;                                   tbl.push_back(v);
    v.raw = {20'hFFFFF, 20'hFFFFF, 16'hFFFF};     tbl.push_back(v);
    v.raw = {20'hFFFFF, 20'd0, 16'd0};            tbl.push_back(v);
    v.raw = {20'd0, 20'hFFFFF, 16'hFFFF};         tbl.push_back(v);
    v.raw = {20'h55555, 20'hAAAAA, 16'h5555};     tbl.push_back(v);
    v.raw = {20'hAAAAA, 20'h55555, 16'hAAAA};     tbl.push_back(v);
    foreach (tbl[i]) send_word(tbl[i].raw, tbl[i].has_exp, tbl[i].exp);
    drain();

    // extreme calibration sets, the typical set twice, then random ones
    for (ph = 0; ph < 8; ph++) begin
      case (ph)
        0: load_cal('1, '1, '1, '1, '1);
        1: load_cal({16'h8000, 16'h8000, 16'hFFFF}, 64'h8000_8000_8000_FFFF,
                    64'h8000_8000_8000_8000, {8'hFF, 16'h8000, 8'hFF, 16'h8000},
                    {8'h80, 12'h800, 12'h800});
        2: load_cal({16'h7FFF, 16'h7FFF, 16'h0000}, 64'h7FFF_7FFF_7FFF_0001,
                    64'h7FFF_7FFF_7FFF_7FFF, {8'h00, 16'h7FFF, 8'h00, 16'h7FFF},
                    {8'h7F, 12'h7FF, 12'h7FF});
        3, 4: load_cal({16'hFC18, 16'd26435, 16'd27504},
                       {16'd2855, 16'hFF4B, 16'hD0D0, 16'd36477},
                       {16'hFFF9, 16'd15500, 16'hDB6F, 16'd140},
                       {8'd0, 16'd362, 8'd75, 16'd6000}, {8'd30, 12'd50, 12'd312});
        default: load_cal({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                          {$urandom, $urandom}, $urandom);
      endcase
      repeat (190) begin
        r = rand_raw();
        send_word(r, 1'b0, z);
      end
      drain();
    end
    if (n_err == 0 && exp_q.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule

// ===== files.f =====
design/esc_pkg.sv
design/esc_stream_if.sv
design/esc_front.sv
design/esc_div.sv
design/esc_post.sv
design/env_sensor_compensation.sv
dv/tb_env_sensor_compensation.sv
